// ===== rtl/core/mrfb_pkg.sv =====
// Package for the Modbus RTU frame builder: byte phases, register indexes and CRC step.
package mrfb_pkg;

    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_SLAVE_ADDRESS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FUNCTION_CODE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_REGISTER = 2'd2;

    // which byte of the current item goes out next
    typedef enum logic [6:0] {
        PH_PFX0 = 7'b0000001,
        PH_PFX1 = 7'b0000010,
        PH_PFX2 = 7'b0000100,
        PH_PFX3 = 7'b0001000,
        PH_DATA = 7'b0010000,
        PH_CRCL = 7'b0100000,
        PH_CRCH = 7'b1000000
    } t_phase;

    // one byte of CRC-16/Modbus, reflected, LSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/modbus_rtu_frame_builder.sv =====
// A payload word accepted mid-frame waits in the item register and moves on into the output
// byte register once that is free. Throughput: one frame byte per cycle while the output is
// not stalled; the first word of a frame goes out after the four prefix bytes, and a word
// with tlast is followed by the two CRC bytes. The single output byte register sets this rate.
// Reset (synchronous, active low) empties both stages, clears the config registers,
// loads the CRC with 0xFFFF and leaves the block outside a frame.
module modbus_rtu_frame_builder
    import mrfb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    // payload in
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [7:0] payload_byte
    input  logic                 s_axis_tlast,   // payload_last
    // frame out
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [7:0]           m_axis_tdata,   // [7:0] frame_byte
    output logic                 m_axis_tlast    // frame_end
);

    logic [7:0]  r_slave_address;
    logic [7:0]  r_function_code;
    logic [15:0] r_target_register;

    logic        r_item_valid, n_item_valid;
    logic [7:0]  r_data;
    logic        r_last;
    logic        r_fresh, n_fresh;
    t_phase      r_phase, n_phase;
    logic        r_in_frame, n_in_frame;
    logic [15:0] r_crc, n_crc;

    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_out_byte, n_out_byte;
    logic        r_out_end, n_out_end;

    t_phase      cur_phase;
    t_phase      adv_phase;
    logic        out_free;
    logic        emit;
    logic        item_done;
    logic        fold;
    logic [7:0]  sel_byte;
    logic        sel_end;
    logic        in_accept;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_address   <= '0;
            r_function_code   <= '0;
            r_target_register <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SLAVE_ADDRESS:   r_slave_address   <= i_cfg_data[7:0];
                REG_FUNCTION_CODE:   r_function_code   <= i_cfg_data[7:0];
                REG_TARGET_REGISTER: r_target_register <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign out_free  = !r_out_valid || m_axis_tready;
    assign emit      = r_item_valid && out_free;
    // a freshly loaded word starts with the prefix unless the frame is already open
    assign cur_phase = r_fresh ? (r_in_frame ? PH_DATA : PH_PFX0) : r_phase;

    always_comb begin
        sel_byte  = r_data;
        sel_end   = 1'b0;
        fold      = 1'b1;
        item_done = 1'b0;
        adv_phase = PH_DATA;
        case (cur_phase)
            PH_PFX0: begin
                sel_byte  = r_slave_address;
                adv_phase = PH_PFX1;
            end
            PH_PFX1: begin
                sel_byte  = r_function_code;
                adv_phase = PH_PFX2;
            end
            PH_PFX2: begin
                sel_byte  = r_target_register[15:8];
                adv_phase = PH_PFX3;
            end
            PH_PFX3: begin
                sel_byte  = r_target_register[7:0];
                adv_phase = PH_DATA;
            end
            PH_DATA: begin
                sel_byte  = r_data;
                adv_phase = PH_CRCL;
                item_done = !r_last;
            end
            PH_CRCL: begin
                sel_byte  = r_crc[7:0];
                fold      = 1'b0;
                adv_phase = PH_CRCH;
            end
            PH_CRCH: begin
                sel_byte  = r_crc[15:8];
                sel_end   = 1'b1;
                fold      = 1'b0;
                item_done = 1'b1;
            end
            default: begin
                fold = 1'b0;
            end
        endcase
    end

    assign s_axis_tready = !r_item_valid || (emit && item_done);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_item_valid = r_item_valid;
        n_fresh      = r_fresh;
        n_phase      = r_phase;
        n_in_frame   = r_in_frame;
        n_crc        = r_crc;
        n_out_valid  = r_out_valid;
        n_out_byte   = r_out_byte;
        n_out_end    = r_out_end;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        if (emit) begin
            n_out_valid = 1'b1;
            n_out_byte  = sel_byte;
            n_out_end   = sel_end;
            n_fresh     = 1'b0;
            n_phase     = adv_phase;
            if (fold) begin
                n_crc = crc_byte(r_crc, sel_byte);
            end
            if (cur_phase == PH_PFX0) begin
                n_in_frame = 1'b1;
            end
            if (cur_phase == PH_CRCH) begin
                n_crc      = CRC_INIT;
                n_in_frame = 1'b0;
            end
            if (item_done) begin
                n_item_valid = 1'b0;
            end
        end

        if (in_accept) begin
            n_item_valid = 1'b1;
            n_fresh      = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
            r_fresh      <= 1'b0;
            r_phase      <= PH_PFX0;
            r_in_frame   <= 1'b0;
            r_crc        <= CRC_INIT;
            r_out_valid  <= 1'b0;
        end else begin
            r_item_valid <= n_item_valid;
            r_fresh      <= n_fresh;
            r_phase      <= n_phase;
            r_in_frame   <= n_in_frame;
            r_crc        <= n_crc;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte <= n_out_byte;
        r_out_end  <= n_out_end;
        if (in_accept) begin
            r_data <= s_axis_tdata;
            r_last <= s_axis_tlast;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_byte;
    assign m_axis_tlast  = r_out_end;

endmodule

// ===== rtl/core/mrfb_checker.sv =====
// Port-level checks for the Modbus RTU frame builder, bound to the top level.
module mrfb_checker
    import mrfb_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       s_axis_tlast,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast
);

    // frames whose last payload word went in but whose closing word has not come out
    logic [1:0] r_open;
    logic       in_last;
    logic       out_last;

    assign in_last  = s_axis_tvalid && s_axis_tready && s_axis_tlast;
    assign out_last = m_axis_tvalid && m_axis_tready && m_axis_tlast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= '0;
        end else begin
            r_open <= r_open + {1'b0, in_last} - {1'b0, out_last};
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output word changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid straight after reset");

    a_end_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_last |-> r_open != 2'd0)
        else $error("frame end with no closed payload run");

    a_open_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open <= 2'd2)
        else $error("more frames pending than the two stages can hold");

endmodule

bind modbus_rtu_frame_builder mrfb_checker u_mrfb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
